// ===== rtl/core/ghf_pkg.sv =====
`default_nettype none

package ghf_pkg;

  localparam int NUM_STATES = 8;
  localparam int IDX_W = 3;
  localparam int TRANS_DEPTH = NUM_STATES * NUM_STATES;

  localparam logic [1:0] KIND_STATE = 2'd0;
  localparam logic [1:0] KIND_TRANS = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic REG_ACTIVE = 1'b0;

  localparam logic [31:0] TWO_PI_Q16 = 32'd411775;
  localparam logic [31:0] LN2_Q16 = 32'd45426;
  localparam logic [31:0] LOG2E_Q16 = 32'd94548;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         to_state;
    logic [2:0]         from_state;
    logic signed [15:0] state_mean;
    logic [31:0]        state_variance;
    logic [15:0]        transition_prob;
    logic signed [15:0] sample;
    logic               first_of_sequence;
    logic               last_of_sequence;
  } ghf_in_t;

  typedef struct packed {
    logic signed [47:0] log_likelihood;
    logic               status;
  } ghf_out_t;

  // request to the divide / square root unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if ((v[51:47] == 5'b00000) || (v[51:47] == 5'b11111)) begin
      r = v[47:0];
    end else if (v[51]) begin
      r = {1'b1, 47'b0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ghf_mul.sv =====
`default_nettype none

module ghf_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/core/ghf_divsqrt.sv =====
`default_nettype none

module ghf_divsqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ghf_pkg::ds_req_t req_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  import ghf_pkg::*;

  logic        busy_q, done_q, sqrt_q;
  logic [5:0]  cnt_q;
  logic [64:0] rem_q, rem_n;
  logic [63:0] quo_q, quo_n;
  logic [63:0] aux_q, aux_n;
  logic [64:0] rem_sh;
  logic [63:0] trial;
  logic        ge;
  logic        last;

  // one quotient bit or one root bit per cycle
  always_comb begin
    rem_sh = {rem_q[63:0], quo_q[63]};
    trial  = quo_q + aux_q;
    if (sqrt_q) begin
      ge    = (rem_q[63:0] >= trial);
      rem_n = ge ? {1'b0, rem_q[63:0] - trial} : rem_q;
      quo_n = ge ? ((quo_q >> 1) + aux_q) : (quo_q >> 1);
      aux_n = aux_q >> 2;
    end else begin
      ge    = (rem_sh >= {1'b0, aux_q});
      rem_n = ge ? (rem_sh - {1'b0, aux_q}) : rem_sh;
      quo_n = {quo_q[62:0], ge};
      aux_n = aux_q;
    end
  end

  assign last = sqrt_q ? (cnt_q == 6'd31) : (cnt_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        sqrt_q <= req_i.is_sqrt;
        if (req_i.is_sqrt) begin
          rem_q <= {1'b0, a_i};
          quo_q <= '0;
          aux_q <= 64'h4000_0000_0000_0000;
        end else begin
          rem_q <= '0;
          quo_q <= a_i;
          aux_q <= b_i;
        end
      end else if (busy_q) begin
        rem_q <= rem_n;
        quo_q <= quo_n;
        aux_q <= aux_n;
        cnt_q <= cnt_q + 6'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/gaussian_hmm_forward_loglik.sv =====
// one item at a time; the bit-serial divide / square root unit dominates the work (16 roots a weight)
// a result transfer is held in an output register, loaded from the emit step once that register is free
// reset: async active low, clears control, probabilities, accumulator and flag; active_states = 8
`default_nettype none

module gaussian_hmm_forward_loglik (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ghf_pkg::ghf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ghf_pkg::ghf_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ghf_pkg::*;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_L_DIV   = 5'd1;
  localparam logic [4:0] S_L_DIVW  = 5'd2;
  localparam logic [4:0] S_L_MUL   = 5'd3;
  localparam logic [4:0] S_L_MULW  = 5'd4;
  localparam logic [4:0] S_LG_NORM = 5'd5;
  localparam logic [4:0] S_LG_SQ   = 5'd6;
  localparam logic [4:0] S_LG_SQW  = 5'd7;
  localparam logic [4:0] S_L_LN    = 5'd8;
  localparam logic [4:0] S_L_LNW   = 5'd9;
  localparam logic [4:0] S_D1      = 5'd10;
  localparam logic [4:0] S_D2      = 5'd11;
  localparam logic [4:0] S_D3      = 5'd12;
  localparam logic [4:0] S_F_END   = 5'd13;
  localparam logic [4:0] S_M_RD    = 5'd14;
  localparam logic [4:0] S_M_MUL   = 5'd15;
  localparam logic [4:0] S_M_ACC   = 5'd16;
  localparam logic [4:0] S_M_PRED  = 5'd17;
  localparam logic [4:0] S_M_BEST  = 5'd18;
  localparam logic [4:0] S_W_CHK   = 5'd19;
  localparam logic [4:0] S_W_E2    = 5'd20;
  localparam logic [4:0] S_P_SH    = 5'd21;
  localparam logic [4:0] S_P_W     = 5'd22;
  localparam logic [4:0] S_W_MUL   = 5'd23;
  localparam logic [4:0] S_W_SET   = 5'd24;
  localparam logic [4:0] S_W_NEXT  = 5'd25;
  localparam logic [4:0] S_N_DIV   = 5'd26;
  localparam logic [4:0] S_N_W     = 5'd27;
  localparam logic [4:0] S_S_LN    = 5'd28;
  localparam logic [4:0] S_S_LNW   = 5'd29;
  localparam logic [4:0] S_EMIT    = 5'd30;

  logic [4:0] st_q, ret_q;
  logic       in_acc, cfg_we;
  ghf_in_t    in_q;
  ghf_out_t   out_q;
  logic       out_valid_q;
  logic       emit_set;
  logic [3:0] active_q;
  logic [3:0] n_act;
  logic [IDX_W-1:0] j_q, i_q;
  logic       j_last, i_last;

  // model stores, written by load items
  logic signed [15:0] mean_q  [NUM_STATES];
  logic [31:0]        inv_q   [NUM_STATES];
  logic signed [31:0] lnorm_q [NUM_STATES];
  logic [15:0]        trans_mem [TRANS_DEPTH];
  logic [15:0]        rd_q;

  // forward recursion state
  logic [31:0]        probs_q [NUM_STATES];
  logic signed [47:0] acc_q;
  logic               uf_q;

  // per-sample scratch
  logic [50:0]        macc_q;
  logic [31:0]        pred_q [NUM_STATES];
  logic signed [49:0] ld_q   [NUM_STATES];
  logic signed [49:0] best_q;
  logic               any_q;
  logic [31:0]        w_q    [NUM_STATES];
  logic [35:0]        sum_q;

  // log2 by repeated squaring
  logic [63:0] lg_x_q;
  logic [5:0]  lg_p_q;
  logic [31:0] lg_m_q;
  logic [22:0] lg_r_q;
  logic [3:0]  lg_k_q;

  // 2^-f by repeated square roots
  logic [15:0] pw_f_q;
  logic [5:0]  pw_ip_q;
  logic [30:0] pw_r_q;
  logic [3:0]  pw_k_q;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  ds_req_t     ds_req;
  logic [63:0] ds_a, ds_b, ds_res;
  logic        ds_done;

  // datapath terms
  logic [31:0]        v1;
  logic signed [16:0] d_s;
  logic [16:0]        ad;
  logic [63:0]        rnd;
  logic [47:0]        q48;
  logic signed [49:0] ld_new;
  logic signed [50:0] delta_s;
  logic               w_ok;
  logic [31:0]        sq_m2;
  logic [63:0]        w_sh;
  logic [31:0]        w_new;
  logic [31:0]        e2_ip;
  logic [30:0]        pw_shift;
  logic               is_load;
  logic signed [24:0] mq_a;
  logic [23:0]        mq_mag;
  logic [23:0]        mq_r;
  logic signed [24:0] mq_ln;
  logic signed [24:0] t_s, th;
  logic signed [31:0] lnorm_new;
  logic signed [47:0] acc_new;

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration port
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ACTIVE);
  assign prdata = (paddr[2] == REG_ACTIVE) ? {28'b0, active_q} : 32'b0;
  assign pready = 1'b1;

  // zero acts as one, above the store depth acts as the depth
  assign n_act = (active_q == 4'd0) ? 4'd1 :
                 (active_q > 4'(NUM_STATES)) ? 4'(NUM_STATES) : active_q;
  assign j_last = (j_q == IDX_W'(n_act - 4'd1));
  assign i_last = (i_q == IDX_W'(n_act - 4'd1));

  // zero variance is taken as one
  assign v1 = (in_q.state_variance == 32'd0) ? 32'd1 : in_q.state_variance;

  // log density: normalizer minus d*d/(2v)
  assign d_s = {in_q.sample[15], in_q.sample} - {mean_q[j_q][15], mean_q[j_q]};
  assign ad  = d_s[16] ? 17'(-d_s) : 17'(d_s);
  assign rnd = mul_p + 64'd32768;
  assign q48 = rnd[63:16];
  assign ld_new = $signed({{18{lnorm_q[j_q][31]}}, lnorm_q[j_q]}) - $signed({2'b0, q48});

  // weight of state j relative to the best log density
  assign delta_s = {best_q[49], best_q} - {ld_q[j_q][49], ld_q[j_q]};
  assign w_ok    = (pred_q[j_q] != 32'd0) && (delta_s < 51'sd16777216);
  assign e2_ip   = rnd[63:32];
  assign pw_shift = pw_f_q[pw_k_q] ? (pw_r_q >> 1) : pw_r_q;
  assign w_sh    = (mul_p >> 30) >> pw_ip_q;
  assign w_new   = w_sh[31:0];

  assign sq_m2 = mul_p[61:30];

  // ln from log2: the load path removes 16 integer bits, the sum path 30
  assign is_load = (st_q == S_L_LN) || (st_q == S_L_LNW);
  assign mq_a    = $signed({2'b0, lg_r_q}) - (is_load ? 25'sd1048576 : 25'sd1966080);
  assign mq_mag  = mq_a[24] ? 24'(-mq_a) : 24'(mq_a);
  assign mq_r    = rnd[39:16];
  assign mq_ln   = mq_a[24] ? -$signed({1'b0, mq_r}) : $signed({1'b0, mq_r});

  // -ln/2 rounded toward zero
  assign t_s       = -mq_ln;
  assign th        = (t_s + $signed({24'b0, t_s[24]})) >>> 1;
  assign lnorm_new = {{7{th[24]}}, th};

  assign acc_new = sat48($signed({{4{acc_q[47]}}, acc_q}) +
                         $signed({{27{mq_ln[24]}}, mq_ln}) +
                         $signed({{2{best_q[49]}}, best_q}));

  // result is loaded when the output register is free or drains this cycle
  assign emit_set = (st_q == S_EMIT) && in_q.last_of_sequence &&
                    (!out_valid_q || !out_stall_i);

  // multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (st_q)
      S_L_MUL: begin
        mul_a = TWO_PI_Q16;
        mul_b = v1;
      end
      S_LG_SQ: begin
        mul_a = lg_m_q;
        mul_b = lg_m_q;
      end
      S_L_LN, S_S_LN: begin
        mul_a = {8'b0, mq_mag};
        mul_b = LN2_Q16;
      end
      S_D1: begin
        mul_a = {15'b0, ad};
        mul_b = {15'b0, ad};
      end
      S_D2: begin
        mul_a = mul_p[31:0];
        mul_b = inv_q[j_q];
      end
      S_M_MUL: begin
        mul_a = probs_q[i_q];
        mul_b = {16'b0, rd_q};
      end
      S_W_CHK: begin
        mul_a = {8'b0, delta_s[23:0]};
        mul_b = LOG2E_Q16;
      end
      S_W_MUL: begin
        mul_a = pred_q[j_q];
        mul_b = {1'b0, pw_r_q};
      end
      default: ;
    endcase
  end

  // divide / root operand select
  always_comb begin
    ds_req = '0;
    ds_a   = 64'd0;
    ds_b   = 64'd0;
    case (st_q)
      S_L_DIV: begin
        ds_req.start = 1'b1;
        ds_a = {32'b0, 32'h8000_0000} + {33'b0, v1[31:1]};
        ds_b = {32'b0, v1};
      end
      S_P_SH: begin
        ds_req.start   = 1'b1;
        ds_req.is_sqrt = 1'b1;
        ds_a = {3'b0, pw_shift, 30'b0};
      end
      S_N_DIV: begin
        ds_req.start = 1'b1;
        ds_a = {2'b0, w_q[j_q], 30'b0} + {29'b0, sum_q[35:1]};
        ds_b = {28'b0, sum_q};
      end
      default: ;
    endcase
  end

  ghf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ghf_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .a_i    (ds_a),
    .b_i    (ds_b),
    .done_o (ds_done),
    .res_o  (ds_res)
  );

  // transition matrix, dest-major, registered read
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.kind == KIND_TRANS)) begin
      trans_mem[{in_data_i.to_state, in_data_i.from_state}] <= in_data_i.transition_prob;
    end
    rd_q <= trans_mem[{j_q, i_q}];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ret_q       <= S_IDLE;
      j_q         <= '0;
      i_q         <= '0;
      any_q       <= 1'b0;
      active_q    <= 4'd8;
      acc_q       <= '0;
      uf_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_STATES; k++) begin
        probs_q[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_q <= pwdata[3:0];
      end
      if (emit_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            in_q <= in_data_i;
            j_q  <= '0;
            i_q  <= '0;
            case (in_data_i.kind)
              KIND_STATE: begin
                if (32'(in_data_i.to_state) < NUM_STATES) st_q <= S_L_DIV;
              end
              KIND_SAMPLE: begin
                if (in_data_i.first_of_sequence) begin
                  ret_q <= S_F_END;
                  st_q  <= S_D1;
                end else begin
                  any_q  <= 1'b0;
                  best_q <= '0;
                  macc_q <= '0;
                  st_q   <= S_M_RD;
                end
              end
              default: ;
            endcase
          end
        end
        // state load: 1/(2v), then -ln(2*pi*v)/2
        S_L_DIV: st_q <= S_L_DIVW;
        S_L_DIVW: begin
          if (ds_done) begin
            inv_q[in_q.to_state]  <= ds_res[31:0];
            mean_q[in_q.to_state] <= in_q.state_mean;
            st_q <= S_L_MUL;
          end
        end
        S_L_MUL: st_q <= S_L_MULW;
        S_L_MULW: begin
          lg_x_q <= mul_p;
          lg_p_q <= 6'd63;
          ret_q  <= S_L_LN;
          st_q   <= S_LG_NORM;
        end
        // log2 subroutine: normalize one bit a cycle, then 16 squarings
        S_LG_NORM: begin
          if (lg_x_q[63]) begin
            lg_m_q <= {1'b0, lg_x_q[63:33]};
            lg_r_q <= {1'b0, lg_p_q, 16'b0};
            lg_k_q <= '0;
            st_q   <= S_LG_SQ;
          end else begin
            lg_x_q <= {lg_x_q[62:0], 1'b0};
            lg_p_q <= lg_p_q - 6'd1;
          end
        end
        S_LG_SQ: st_q <= S_LG_SQW;
        S_LG_SQW: begin
          if (sq_m2[31]) begin
            lg_m_q <= {1'b0, sq_m2[31:1]};
            lg_r_q <= lg_r_q + {7'b0, 16'h8000 >> lg_k_q};
          end else begin
            lg_m_q <= sq_m2;
          end
          lg_k_q <= lg_k_q + 4'd1;
          st_q   <= (lg_k_q == 4'd15) ? ret_q : S_LG_SQ;
        end
        S_L_LN: st_q <= S_L_LNW;
        S_L_LNW: begin
          lnorm_q[in_q.to_state] <= lnorm_new;
          st_q <= S_IDLE;
        end
        // log density subroutine for state j
        S_D1: st_q <= S_D2;
        S_D2: st_q <= S_D3;
        S_D3: begin
          ld_q[j_q] <= ld_new;
          st_q <= ret_q;
        end
        // first sample: all probability in state 0
        S_F_END: begin
          for (int k = 0; k < NUM_STATES; k++) begin
            probs_q[k] <= '0;
          end
          probs_q[0] <= ONE_Q30;
          uf_q  <= 1'b0;
          acc_q <= sat48({{2{ld_q[0][49]}}, ld_q[0]});
          st_q  <= S_EMIT;
        end
        // pred = T * probs, one product per pass through the read, multiply and accumulate steps
        S_M_RD:  st_q <= S_M_MUL;
        S_M_MUL: st_q <= S_M_ACC;
        S_M_ACC: begin
          macc_q <= macc_q + {3'b0, mul_p[47:0]};
          if (i_last) begin
            st_q <= S_M_PRED;
          end else begin
            i_q  <= i_q + 1'b1;
            st_q <= S_M_RD;
          end
        end
        S_M_PRED: begin
          pred_q[j_q] <= (macc_q[50:48] != 3'd0) ? 32'hFFFF_FFFF : macc_q[47:16];
          ret_q <= S_M_BEST;
          st_q  <= S_D1;
        end
        S_M_BEST: begin
          if ((pred_q[j_q] != 32'd0) && (!any_q || (ld_q[j_q] > best_q))) begin
            best_q <= ld_q[j_q];
            any_q  <= 1'b1;
          end
          if (j_last) begin
            j_q   <= '0;
            sum_q <= '0;
            st_q  <= S_W_CHK;
          end else begin
            j_q    <= j_q + 1'b1;
            i_q    <= '0;
            macc_q <= '0;
            st_q   <= S_M_RD;
          end
        end
        // weights scaled by the best log density
        S_W_CHK: begin
          if (w_ok) begin
            st_q <= S_W_E2;
          end else begin
            w_q[j_q] <= '0;
            st_q <= S_W_NEXT;
          end
        end
        S_W_E2: begin
          if (e2_ip < 32'd63) begin
            pw_f_q  <= rnd[31:16];
            pw_ip_q <= e2_ip[5:0];
            pw_r_q  <= ONE_Q30[30:0];
            pw_k_q  <= '0;
            st_q    <= S_P_SH;
          end else begin
            w_q[j_q] <= '0;
            st_q <= S_W_NEXT;
          end
        end
        S_P_SH: st_q <= S_P_W;
        S_P_W: begin
          if (ds_done) begin
            pw_r_q <= ds_res[30:0];
            pw_k_q <= pw_k_q + 4'd1;
            st_q   <= (pw_k_q == 4'd15) ? S_W_MUL : S_P_SH;
          end
        end
        S_W_MUL: st_q <= S_W_SET;
        S_W_SET: begin
          w_q[j_q] <= w_new;
          sum_q <= sum_q + {4'b0, w_new};
          st_q  <= S_W_NEXT;
        end
        S_W_NEXT: begin
          if (j_last) begin
            if (sum_q == '0) begin
              uf_q <= 1'b1;
              st_q <= S_EMIT;
            end else begin
              j_q  <= '0;
              st_q <= S_N_DIV;
            end
          end else begin
            j_q  <= j_q + 1'b1;
            st_q <= S_W_CHK;
          end
        end
        // normalize by the sum, then add ln(sum) and the best log density
        S_N_DIV: st_q <= S_N_W;
        S_N_W: begin
          if (ds_done) begin
            probs_q[j_q] <= ds_res[31:0];
            if (j_last) begin
              lg_x_q <= {28'b0, sum_q};
              lg_p_q <= 6'd63;
              ret_q  <= S_S_LN;
              st_q   <= S_LG_NORM;
            end else begin
              j_q  <= j_q + 1'b1;
              st_q <= S_N_DIV;
            end
          end
        end
        S_S_LN: st_q <= S_S_LNW;
        S_S_LNW: begin
          acc_q <= acc_new;
          st_q  <= S_EMIT;
        end
        // for the last sample of a sequence, result transfer waits for a free output register
        S_EMIT: begin
          if (!in_q.last_of_sequence) begin
            st_q <= S_IDLE;
          end else if (emit_set) begin
            out_q.log_likelihood <= acc_q;
            out_q.status         <= uf_q;
            st_q                 <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a result only appears from the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(st_q) == S_EMIT))
    else $error("result raised outside emit step");

  // normalizing never divides by zero
  a_sum_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_N_DIV) |-> (sum_q != '0))
    else $error("normalize with zero sum");

  // state index stays inside the active states while busy
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> (({1'b0, j_q} < n_act) && ({1'b0, i_q} < n_act)))
    else $error("state index out of range");

endmodule

`default_nettype wire
